### rtl/sliding_window_median_top_defines.svh
// ---------------------------------------------------------------------------
// sliding window median assertion macros
// shared assertion shorthands for the median filter rtl
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SWM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg
// shared constants, state encoding and control structs of the median filter
// ---------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int CFG_BITS        = 7;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } swm_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic sweep;
    logic finish;
    logic load_out;
  } swm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_done;
    logic dvalid;
    logic emit;
    logic out_busy;
  } swm_stat_t;

endpackage

### rtl/swm_ctrl.sv
// ---------------------------------------------------------------------------
// swm_ctrl
// sequencer for one request: accept, sorted-memory sweep, result hand-off
// ---------------------------------------------------------------------------
module swm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  swm_pkg::swm_stat_t stat_i,
  output swm_pkg::swm_cmd_t  cmd_o,
  output logic              in_stall_o
);

  swm_pkg::swm_state_e state_q, state_d;
  logic                pass_end;

  assign pass_end = stat_i.rd_done && !stat_i.dvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = swm_pkg::ST_SWEEP;
      end
      swm_pkg::ST_SWEEP: begin
        if (pass_end) state_d = swm_pkg::ST_DONE;
      end
      swm_pkg::ST_DONE: begin
        if (!stat_i.emit || !stat_i.out_busy) state_d = swm_pkg::ST_IDLE;
      end
      default: state_d = swm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      swm_pkg::ST_SWEEP: begin
        cmd_o.sweep  = !pass_end;
        cmd_o.finish = pass_end;
      end
      swm_pkg::ST_DONE: begin
        cmd_o.load_out = stat_i.emit && !stat_i.out_busy;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

### rtl/swm_datapath.sv
// ---------------------------------------------------------------------------
// swm_datapath
// arrival ring, in-place sorted window update and median output register
// ---------------------------------------------------------------------------
`include "sliding_window_median_top_defines.svh"

module swm_datapath #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic        [swm_pkg::CFG_BITS-1:0] cfg_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  logic                               start_req_i,
  input  logic                               out_stall_i,
  input  swm_pkg::swm_cmd_t                  cmd_i,
  output swm_pkg::swm_stat_t                 stat_o,
  output logic                               out_valid_o,
  output logic signed [SAMPLE_BITS:0]        median_doubled_o
);

  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMPW = (CW > swm_pkg::CFG_BITS) ? CW : swm_pkg::CFG_BITS;

  // configuration and window bookkeeping
  logic [swm_pkg::CFG_BITS-1:0] win_q;
  logic [CW-1:0]                fill_q, fill_d;
  logic [IW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                win_k, lo_idx, hi_idx, fill_eff;
  logic                         rem_now;
  logic [IW-1:0]                ring_waddr;

  // sweep state
  logic [CW-1:0] cnt_q, rd_idx_q, wr_idx_q;
  logic          rem_en_q, emit_q, dvalid_q, removed_q, inserted_q, buf_vld_q;
  logic          removed_d, inserted_d, buf_vld_d;
  logic          rd_issue, sort_we, drop;

  // payload
  logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] sort_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] sample_q, ring_old_q, sort_rd_q, buf_q, buf_d;
  logic signed [SAMPLE_BITS-1:0] sort_wdata, med_lo_q, med_hi_q;
  logic signed [SAMPLE_BITS:0]   out_q;
  logic                          out_vld_q;

  // effective window size: zero acts as one, large values clamp
  always_comb begin
    if (win_q == '0) begin
      win_k = CW'(1);
    end else if (CMPW'(win_q) > CMPW'(WINDOW_MAX)) begin
      win_k = CW'(WINDOW_MAX);
    end else begin
      win_k = CW'(win_q);
    end
  end

  assign lo_idx     = (win_k - CW'(1)) >> 1;
  assign hi_idx     = win_k >> 1;
  assign fill_eff   = start_req_i ? '0 : fill_q;
  assign rem_now    = (fill_eff == win_k);
  assign ring_waddr = rem_now ? ptr_q : fill_eff[IW-1:0];

  always_comb begin
    fill_d = rem_now ? fill_eff : fill_eff + CW'(1);
    if (!rem_now) begin
      ptr_d = '0;
    end else if ((CW'(ptr_q) + CW'(1)) == win_k) begin
      ptr_d = '0;
    end else begin
      ptr_d = ptr_q + IW'(1);
    end
  end

  // merge step: drop one copy of the leaving value, slot the new sample in
  always_comb begin
    sort_we    = 1'b0;
    sort_wdata = sample_q;
    drop       = 1'b0;
    buf_d      = buf_q;
    buf_vld_d  = buf_vld_q;
    removed_d  = removed_q;
    inserted_d = inserted_q;
    if (cmd_i.sweep && dvalid_q) begin
      drop = rem_en_q && !removed_q && (sort_rd_q == ring_old_q);
      if (drop) removed_d = 1'b1;
      if (buf_vld_q) begin
        sort_we    = 1'b1;
        sort_wdata = buf_q;
        buf_d      = sort_rd_q;
        buf_vld_d  = !drop;
      end else if (!drop) begin
        if (!inserted_q && (sort_rd_q > sample_q)) begin
          sort_we    = 1'b1;
          sort_wdata = sample_q;
          buf_d      = sort_rd_q;
          buf_vld_d  = 1'b1;
          inserted_d = 1'b1;
        end else begin
          sort_we    = 1'b1;
          sort_wdata = sort_rd_q;
        end
      end
    end else if (cmd_i.finish) begin
      if (buf_vld_q) begin
        sort_we    = 1'b1;
        sort_wdata = buf_q;
        buf_vld_d  = 1'b0;
      end else if (!inserted_q) begin
        sort_we    = 1'b1;
        sort_wdata = sample_q;
        inserted_d = 1'b1;
      end
    end
  end

  assign rd_issue = cmd_i.sweep && (rd_idx_q != cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= swm_pkg::WINDOW_RESET;
      fill_q     <= '0;
      ptr_q      <= '0;
      cnt_q      <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      rem_en_q   <= 1'b0;
      emit_q     <= 1'b0;
      dvalid_q   <= 1'b0;
      removed_q  <= 1'b0;
      inserted_q <= 1'b0;
      buf_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q  <= cfg_wdata_i;
        fill_q <= '0;
        ptr_q  <= '0;
      end else if (cmd_i.accept) begin
        fill_q <= fill_d;
        ptr_q  <= ptr_d;
      end
      if (cmd_i.accept) begin
        cnt_q      <= fill_eff;
        rem_en_q   <= rem_now;
        emit_q     <= (fill_d == win_k);
        rd_idx_q   <= '0;
        wr_idx_q   <= '0;
        dvalid_q   <= 1'b0;
        removed_q  <= 1'b0;
        inserted_q <= 1'b0;
        buf_vld_q  <= 1'b0;
      end else begin
        dvalid_q   <= rd_issue;
        removed_q  <= removed_d;
        inserted_q <= inserted_d;
        buf_vld_q  <= buf_vld_d;
        if (rd_issue) rd_idx_q <= rd_idx_q + CW'(1);
        if (sort_we) wr_idx_q <= wr_idx_q + CW'(1);
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // arrival ring: write new sample, fetch the leaving one
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ring_mem[ring_waddr] <= sample_i;
      ring_old_q           <= ring_mem[ptr_q];
    end
  end

  // sorted window, updated in place during the sweep
  always_ff @(posedge clk_i) begin
    if (sort_we) sort_mem[wr_idx_q[IW-1:0]] <= sort_wdata;
    if (rd_issue) sort_rd_q <= sort_mem[rd_idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) sample_q <= sample_i;
    buf_q <= buf_d;
    if (sort_we && (wr_idx_q == lo_idx)) med_lo_q <= sort_wdata;
    if (sort_we && (wr_idx_q == hi_idx)) med_hi_q <= sort_wdata;
    if (cmd_i.load_out) begin
      out_q <= {med_lo_q[SAMPLE_BITS-1], med_lo_q} + {med_hi_q[SAMPLE_BITS-1], med_hi_q};
    end
  end

  assign stat_o.rd_done  = (rd_idx_q == cnt_q);
  assign stat_o.dvalid   = dvalid_q;
  assign stat_o.emit     = emit_q;
  assign stat_o.out_busy = out_vld_q && out_stall_i;

  assign out_valid_o      = out_vld_q;
  assign median_doubled_o = out_q;

  `SWM_ASSERT_ALWAYS(a_fill_bound, fill_q <= win_k, "fill count above window size")
  `SWM_ASSERT_IMP(a_wr_bound, sort_we, wr_idx_q < win_k, "sorted write past window")
  `SWM_ASSERT_IMP(a_old_found, cmd_i.finish && rem_en_q, removed_q, "leaving value not found")
  `SWM_ASSERT_IMP(a_full_pass, cmd_i.load_out, wr_idx_q == win_k, "result load after short pass")

endmodule

### rtl/sliding_window_median_top.sv
// ---------------------------------------------------------------------------
// sliding_window_median_top
// streaming median over the most recent window_size signed samples
//
// input channel: sample_i and start_req_i, taken when in_valid_i is high and
// in_stall_o is low. start_req_i empties the window before its sample enters.
// output channel: median_doubled_o (twice the median, exact) is delivered when
// out_valid_o is high and out_stall_i is low. no result until the window fills.
// config: cfg_we_i writes window_size from cfg_wdata_i and empties the window;
// write only while the block is idle. zero acts as one, sizes above the
// window depth clamp to it.
// throughput: a new request is taken only in the idle state, so not before the
// previous request has finished its sweep and, when a result is due, its
// hand-off. the sweep reads the sorted-window memory one entry per cycle on its
// read port over fill entries, fill being the samples held before the request.
// result: out_valid_o rises once the sequencer, after the sweep, loads the output register.
// reset: window empty, window_size back to 3; memories need no clearing.
// a stalled result sits in the output register; the next request is still
// taken and its sweep runs, the hand-off waits until the register frees up.
// ---------------------------------------------------------------------------
module sliding_window_median_top #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic        [swm_pkg::CFG_BITS-1:0] cfg_wdata_i,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]      sample_i,
  input  logic                               start_req_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [SAMPLE_BITS:0]        median_doubled_o
);

  swm_pkg::swm_cmd_t  cmd;
  swm_pkg::swm_stat_t stat;

  // sequencer: idle, sweep of the sorted window, result hand-off
  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // ring, sorted memory and output register
  swm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (sample_i),
    .start_req_i      (start_req_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .median_doubled_o (median_doubled_o)
  );

endmodule
